// File: hdl/cvl_pkg.sv
// Shared widths, constants and sideband type for the cable vector unit.
// No dependencies; every other file imports this package.
package cvl_pkg;

  localparam int unsigned CoordW = 31;  // input coordinate width
  localparam int unsigned DiffW  = 32;  // signed difference width
  localparam int unsigned MagW   = 31;  // magnitude of a difference
  localparam int unsigned SqW    = 62;  // square of a magnitude
  localparam int unsigned SumW   = 64;  // sum of three squares
  localparam int unsigned LenW   = 32;  // root width
  localparam int unsigned RemW   = 34;  // root remainder width
  localparam int unsigned DirFrac = 16;
  localparam int unsigned QuoW   = DirFrac + 1;       // quotient never exceeds one
  localparam int unsigned NumW   = MagW + DirFrac + 2;  // rounded dividend width
  localparam int unsigned DirW   = 18;
  localparam logic [QuoW-1:0] DirOne = QuoW'(1) << DirFrac;

  // Per item data that rides along the root and divide pipelines
  typedef struct packed {
    logic [MagW-1:0] mag_x;
    logic [MagW-1:0] mag_y;
    logic [MagW-1:0] mag_z;
    logic [2:0]      neg;
    logic            zero;
  } cvl_side_t;

endpackage

// File: hdl/cvl_if.sv
// Valid/ready channel interfaces for input and result beats.
// Depends on cvl_pkg for field widths.
interface cvl_in_if import cvl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] anchor_x;
  logic signed [CoordW-1:0] anchor_y;
  logic signed [CoordW-1:0] anchor_z;
  logic signed [CoordW-1:0] platform_x;
  logic signed [CoordW-1:0] platform_y;
  logic signed [CoordW-1:0] platform_z;

  modport source (output valid, anchor_x, anchor_y, anchor_z,
                  platform_x, platform_y, platform_z, input ready);
  modport sink   (input valid, anchor_x, anchor_y, anchor_z,
                  platform_x, platform_y, platform_z, output ready);
endinterface

interface cvl_out_if import cvl_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [DirW-1:0] dir_x;
  logic signed [DirW-1:0] dir_y;
  logic signed [DirW-1:0] dir_z;
  logic [LenW-1:0]        cable_len;
  logic                   zero_length;

  modport source (output valid, dir_x, dir_y, dir_z, cable_len, zero_length,
                  input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, cable_len, zero_length,
                  output ready);
endinterface

// File: hdl/cvl_div_lane.sv
// One lane of the pipelined restoring divider, one quotient bit per stage.
// Depends on cvl_pkg for widths.
module cvl_div_lane import cvl_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [LenW-1:0] den_i,
  output logic [QuoW-1:0] quo_o
);

  logic [LenW-1:0] rem_q [QuoW+1];
  logic [QuoW-1:0] low_q [QuoW+1];
  logic [LenW-1:0] den_q [QuoW+1];
  logic [QuoW-1:0] quo_q [QuoW+1];

  // Load: the top dividend bits start below the divisor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i[NumW-1:QuoW];
      low_q[0] <= num_i[QuoW-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
    end
  end

  // Advance one quotient bit per stage
  for (genvar j = 0; j < QuoW; j++) begin : g_stage
    logic [LenW:0] shifted;
    logic          ge;
    assign shifted = {rem_q[j], low_q[j][QuoW-1]};
    assign ge      = shifted >= {1'b0, den_q[j]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= ge ? LenW'(shifted - {1'b0, den_q[j]}) : shifted[LenW-1:0];
        low_q[j+1] <= {low_q[j][QuoW-2:0], 1'b0};
        den_q[j+1] <= den_q[j];
        quo_q[j+1] <= {quo_q[j][QuoW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QuoW];

endmodule

// File: hdl/cable_vector_length_and_direction_unit.sv
// Top level of the cable vector length and direction unit.
// Depends on cvl_pkg, cvl_if and cvl_div_lane.

// Takes one anchor/platform pair per cycle and returns its cable length
// (floor of the Euclidean norm, same fraction bits as the inputs) and the
// rounded Q2.16 unit direction. A zero vector gives zero direction, zero length
// and zero_length set. Throughput is one beat per cycle. Stages: subtract,
// square, sum, 32 root stages (one result bit each), the divider load, 17
// divider stages (one quotient bit each) and the output register. The whole
// pipeline holds while a finished result waits to be taken.
module cable_vector_length_and_direction_unit import cvl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cvl_in_if.sink     in_i,
  cvl_out_if.source  out_o
);

  localparam int unsigned RootSt = LenW;

  logic en;
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // Stage 1: differences
  logic signed [DiffW-1:0] d_q [3];
  logic                    v1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q[0] <= DiffW'(in_i.platform_x) - DiffW'(in_i.anchor_x);
      d_q[1] <= DiffW'(in_i.platform_y) - DiffW'(in_i.anchor_y);
      d_q[2] <= DiffW'(in_i.platform_z) - DiffW'(in_i.anchor_z);
    end
  end

  // Stage 2: magnitudes and squares
  logic [MagW-1:0] m_q [3];
  logic [SqW-1:0]  sq_q [3];
  logic [2:0]      n2_q;
  logic            v2_q;
  for (genvar i = 0; i < 3; i++) begin : g_sq
    logic [MagW-1:0] m;
    assign m = d_q[i][DiffW-1] ? MagW'(-d_q[i]) : d_q[i][MagW-1:0];
    always_ff @(posedge clk_i) begin
      if (en) begin
        m_q[i]  <= m;
        sq_q[i] <= SqW'(m) * SqW'(m);
        n2_q[i] <= d_q[i][DiffW-1];
      end
    end
  end

  // Stage 3: sum of squares
  logic [SumW-1:0] sum_q;
  cvl_side_t       s3_q;
  logic            v3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q      <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
      s3_q.mag_x <= m_q[0];
      s3_q.mag_y <= m_q[1];
      s3_q.mag_z <= m_q[2];
      s3_q.neg   <= n2_q;
      s3_q.zero  <= (m_q[0] == '0) && (m_q[1] == '0) && (m_q[2] == '0);
    end
  end

  // Root pipeline: one result bit per stage
  logic [RemW-1:0] rem_q  [RootSt+1];
  logic [LenW-1:0] root_q [RootSt+1];
  logic [SumW-1:0] x_q    [RootSt+1];
  cvl_side_t       rs_q   [RootSt+1];

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign x_q[0]    = sum_q;
  assign rs_q[0]   = s3_q;

  for (genvar k = 0; k < RootSt; k++) begin : g_root
    logic [RemW+1:0] shifted;
    logic [RemW+1:0] trial;
    logic            ge;
    assign shifted = {rem_q[k], x_q[k][SumW-1 -: 2]};
    assign trial   = (RemW+2)'({root_q[k], 2'b01});
    assign ge      = shifted >= trial;
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k+1]  <= ge ? RemW'(shifted - trial) : shifted[RemW-1:0];
        root_q[k+1] <= {root_q[k][LenW-2:0], ge};
        x_q[k+1]    <= {x_q[k][SumW-3:0], 2'b00};
        rs_q[k+1]   <= rs_q[k];
      end
    end
  end

  // Dividers: rounded |d| * 2^16 / len per axis
  logic [LenW-1:0] len;
  cvl_side_t       sr;
  logic [QuoW-1:0] quo [3];
  assign len = root_q[RootSt];
  assign sr  = rs_q[RootSt];

  cvl_div_lane u_div_x (.clk_i, .en_i(en),
    .num_i(NumW'({sr.mag_x, DirFrac'(0)}) + NumW'(len >> 1)), .den_i(len), .quo_o(quo[0]));
  cvl_div_lane u_div_y (.clk_i, .en_i(en),
    .num_i(NumW'({sr.mag_y, DirFrac'(0)}) + NumW'(len >> 1)), .den_i(len), .quo_o(quo[1]));
  cvl_div_lane u_div_z (.clk_i, .en_i(en),
    .num_i(NumW'({sr.mag_z, DirFrac'(0)}) + NumW'(len >> 1)), .den_i(len), .quo_o(quo[2]));

  // Delay length and sideband alongside the divider stages
  logic [LenW-1:0] dl_q [QuoW+2];
  cvl_side_t       ds_q [QuoW+2];
  assign dl_q[0] = len;
  assign ds_q[0] = sr;
  for (genvar j = 0; j <= QuoW; j++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        dl_q[j+1] <= dl_q[j];
        ds_q[j+1] <= ds_q[j];
      end
    end
  end

  // Valid bits for every stage
  localparam int unsigned ValidSt = RootSt + QuoW + 1;
  logic [ValidSt-1:0] vp_q;
  logic               out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      vp_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      vp_q        <= {vp_q[ValidSt-2:0], v3_q};
      out_valid_q <= vp_q[ValidSt-1];
    end
  end

  // Output register: clamp, apply sign, zero override
  logic signed [DirW-1:0] dir_q [3];
  logic [LenW-1:0]        len_q;
  logic                   zero_q;
  cvl_side_t              fs;
  assign fs = ds_q[QuoW+1];
  for (genvar i = 0; i < 3; i++) begin : g_out
    logic [QuoW-1:0] qc;
    logic [DirW-1:0] mg;
    assign qc = (quo[i] > DirOne) ? DirOne : quo[i];
    assign mg = DirW'(qc);
    always_ff @(posedge clk_i) begin
      if (en) begin
        dir_q[i] <= fs.zero ? '0 : (fs.neg[i] ? -mg : mg);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      len_q  <= fs.zero ? '0 : dl_q[QuoW+1];
      zero_q <= fs.zero;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.dir_x       = dir_q[0];
  assign out_o.dir_y       = dir_q[1];
  assign out_o.dir_z       = dir_q[2];
  assign out_o.cable_len   = len_q;
  assign out_o.zero_length = zero_q;

  // Zero flag and nonzero length agree
  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.zero_length == (out_o.cable_len == '0)))
    else $error("zero flag and length disagree");
  // Zero vector gives zero direction
  a_zero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.zero_length) |->
      (out_o.dir_x == '0 && out_o.dir_y == '0 && out_o.dir_z == '0))
    else $error("nonzero direction for zero vector");
  // Direction components stay within one
  a_dir_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.dir_x <= 18'sd65536 && out_o.dir_x >= -18'sd65536 &&
                     out_o.dir_y <= 18'sd65536 && out_o.dir_y >= -18'sd65536 &&
                     out_o.dir_z <= 18'sd65536 && out_o.dir_z >= -18'sd65536))
    else $error("direction component out of range");
  // Pipeline holds while a result is stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> $stable(vp_q) && out_o.valid)
    else $error("pipeline moved during stall");

endmodule
